// File: hw/rtl/eqhrs_pkg.sv
// Shared package for the equatorial to horizontal rise/set unit.
// Widths, pipeline types, CORDIC step table and fixed-point helpers.
// No dependencies.
`default_nettype none

package eqhrs_pkg;

  localparam int ANGLE_BITS   = 32;
  localparam int OBJECT_COUNT = 11;
  localparam int CORDIC_STEPS = 31;
  localparam int SHIFT_W      = $clog2(CORDIC_STEPS);
  localparam int OBJ_IW       = 4;
  localparam int ROT_W        = 34;              // Q2.30 plus headroom
  localparam int VEC_W        = 36;              // vector components grow by the CORDIC gain
  localparam int Z_W          = ANGLE_BITS + 2;
  localparam int DIV_STEPS    = 40;
  localparam int DEN_W        = 17;
  localparam int TH_W         = 43;
  localparam int FRAC         = 30;

  localparam logic signed [ROT_W-1:0] KINV        = ROT_W'(652032874);
  localparam logic signed [TH_W-1:0]  REFRACT_ALT = -TH_W'(6760994);
  localparam logic [31:0]             HALF_DEGREE = 32'd5965232;
  localparam logic [39:0]             MOON_K      = 40'd8251518;
  localparam logic signed [31:0]      DOWN_ALT    = -32'sd1073741824;
  localparam logic [63:0]             INV_TWO_PI  = 64'h28BE60DB9391054A;

  localparam logic [3:0] OBJ_SUN   = 4'd0;
  localparam logic [3:0] OBJ_MOON  = 4'd3;
  localparam logic [3:0] OBJ_PLUTO = 4'd9;

  localparam logic [2:0] ST_SET     = 3'd0;
  localparam logic [2:0] ST_RISING  = 3'd1;
  localparam logic [2:0] ST_SETTING = 3'd2;
  localparam logic [2:0] ST_UP      = 3'd3;
  localparam logic [2:0] ST_TRANSIT = 3'd4;

  localparam logic REG_LAT = 1'b0;
  localparam logic REG_LON = 1'b1;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    logic                    neg;
  } rot_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [Z_W-1:0]   z;
  } vec_t;

  typedef struct packed {
    logic [DEN_W-1:0]     rem;
    logic [DIV_STEPS-1:0] num;
    logic [DEN_W-1:0]     den;
  } div_t;

  typedef struct packed {
    logic [3:0]              idx;
    logic                    hide;
    logic [31:0]             ha;
    logic [23:0]             sun_d;
    logic [23:0]             moon_d;
    logic [DIV_STEPS-1:0]    par;
    logic signed [VEC_W-1:0] up;
    logic [31:0]             az;
  } sb_t;

  // arctan(2^-i) in turns, rounded to the angle LSB; evaluated at elaboration
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic signed [63:0] s;
    logic [63:0]        term;
    logic [127:0]       prod;
    logic [63:0]        turns;
    int                 e;
    int                 k;
    s = '0;
    if (i == 0) return Z_W'(64'd1 << (ANGLE_BITS - 3));
    for (k = 0; k < 32; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (k[0]) s = s - $signed(term);
        else s = s + $signed(term);
      end
    end
    prod  = {64'b0, s} * {64'b0, INV_TWO_PI};
    turns = prod[127:64] + (64'd1 << (61 - ANGLE_BITS));
    return Z_W'(turns >> (62 - ANGLE_BITS));
  endfunction

  function automatic logic [ANGLE_BITS-1:0] from32(input logic [31:0] a);
    return ANGLE_BITS'({a, 16'b0} >> (48 - ANGLE_BITS));
  endfunction

  function automatic logic [31:0] to32(input logic [ANGLE_BITS-1:0] a);
    return 32'({a, 32'b0} >> ANGLE_BITS);
  endfunction

  // Q2.30 product, floor
  function automatic logic signed [ROT_W-1:0] vmul(input logic signed [ROT_W-1:0] a,
                                                   input logic signed [ROT_W-1:0] b);
    logic signed [2*ROT_W-1:0] p;
    p = a * b;
    return ROT_W'(p >>> FRAC);
  endfunction

  // half-turn fold into [-90, 90] degrees, start vector 1/K on x
  function automatic rot_t rot_init(input logic [31:0] a32);
    logic [ANGLE_BITS-1:0] a;
    logic signed [Z_W-1:0] z;
    logic signed [Z_W-1:0] half;
    logic signed [Z_W-1:0] quarter;
    rot_t                  r;
    a       = from32(a32);
    z       = Z_W'($signed(a));
    half    = Z_W'(1) <<< (ANGLE_BITS - 1);
    quarter = Z_W'(1) <<< (ANGLE_BITS - 2);
    r.neg   = 1'b0;
    if (z > quarter) begin
      z     = z - half;
      r.neg = 1'b1;
    end else if (z < -quarter) begin
      z     = z + half;
      r.neg = 1'b1;
    end
    r.x = KINV;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  function automatic vec_t vec_init(input logic signed [VEC_W-1:0] x,
                                    input logic signed [VEC_W-1:0] y);
    vec_t v;
    if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.z = Z_W'(1) <<< (ANGLE_BITS - 1);
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/eqhrs_rot_cell.sv
// One rotation-mode CORDIC micro-rotation with its output register.
// Depends on eqhrs_pkg.
`default_nettype none

module eqhrs_rot_cell import eqhrs_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SHIFT_W-1:0]    shift,
  input  logic signed [Z_W-1:0] step,
  input  rot_t                  d,
  output rot_t                  q
);

  rot_t                    nxt;
  logic signed [ROT_W-1:0] dx;
  logic signed [ROT_W-1:0] dy;

  always_comb begin
    dx      = d.x >>> shift;
    dy      = d.y >>> shift;
    nxt.neg = d.neg;
    if (d.z >= 0) begin
      nxt.x = d.x - dy;
      nxt.y = d.y + dx;
      nxt.z = d.z - step;
    end else begin
      nxt.x = d.x + dy;
      nxt.y = d.y - dx;
      nxt.z = d.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/eqhrs_vec_cell.sv
// One vectoring-mode CORDIC micro-rotation with its output register.
// Depends on eqhrs_pkg.
`default_nettype none

module eqhrs_vec_cell import eqhrs_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SHIFT_W-1:0]    shift,
  input  logic signed [Z_W-1:0] step,
  input  vec_t                  d,
  output vec_t                  q
);

  vec_t                    nxt;
  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;

  always_comb begin
    dx = d.x >>> shift;
    dy = d.y >>> shift;
    if (d.y > 0) begin
      nxt.x = d.x + dy;
      nxt.y = d.y - dx;
      nxt.z = d.z + step;
    end else begin
      nxt.x = d.x - dy;
      nxt.y = d.y + dx;
      nxt.z = d.z - step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/eqhrs_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on eqhrs_pkg.
`default_nettype none

module eqhrs_div_cell import eqhrs_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t d,
  output div_t q
);

  div_t         nxt;
  logic [DEN_W:0] t;
  logic         qbit;

  always_comb begin
    t       = {d.rem, d.num[DIV_STEPS-1]};
    qbit    = (t >= {1'b0, d.den});
    nxt.den = d.den;
    nxt.rem = qbit ? DEN_W'(t - {1'b0, d.den}) : DEN_W'(t);
    nxt.num = {d.num[DIV_STEPS-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/equatorial_to_horizontal_rise_set_unit.sv
// Throughput: one item per cycle; the whole chain advances together and holds
// only while a finished result waits at the output and out_ready is low.
// Reset (rst, synchronous): clears site registers, stage valid bits and
// the per-object last altitude store to minus ninety degrees.
`default_nettype none

module equatorial_to_horizontal_rise_set_unit import eqhrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  object_index,
  input  logic [31:0] right_ascension,
  input  logic signed [31:0] declination,
  input  logic [31:0] sidereal_time,
  input  logic [23:0] sun_diameter,
  input  logic [23:0] moon_diameter,
  input  logic [16:0] moon_distance_ratio,
  input  logic        position_valid,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hour_angle,
  output logic signed [31:0] altitude,
  output logic signed [31:0] azimuth,
  output logic [2:0]  visibility_status,
  output logic        hidden
);

  // Pipeline positions:
  //   0        input register, hour angle
  //   1..31    three rotation chains (latitude, declination, hour angle)
  //   32, 33   products, then south/west/up
  //   34..64   vectoring chain for azimuth and horizontal magnitude
  //   65       magnitude gain correction
  //   66..96   vectoring chain for altitude
  //   1..40    Moon parallax divider runs alongside
  localparam int LAST     = 96;
  localparam int P_UP     = 34;
  localparam int P_PAR    = DIV_STEPS + 1;
  localparam int P_AZ     = 65;

  logic [31:0] site_latitude;
  logic [31:0] site_longitude;
  logic        adv;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LON) ? site_longitude : site_latitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      site_latitude  <= '0;
      site_longitude <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_LAT: site_latitude  <= pwdata;
        REG_LON: site_longitude <= pwdata;
        default: ;
      endcase
    end
  end

  // Whole chain moves when the output register is free or being drained.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- valid bits and sideband line ----------------
  logic vld [0:LAST];
  sb_t  sb  [0:LAST];
  logic [31:0] p0_dec;
  div_t div [0:DIV_STEPS];
  logic [DEN_W-1:0] den_in;

  assign den_in = (moon_distance_ratio == '0) ? DEN_W'(1) : moon_distance_ratio;

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_valid;
  end

  // input transfer captures the item and the local hour angle
  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0].idx    <= object_index;
      sb[0].hide   <= (object_index == OBJ_PLUTO) && !position_valid;
      sb[0].ha     <= sidereal_time - site_longitude - right_ascension;
      sb[0].sun_d  <= sun_diameter;
      sb[0].moon_d <= moon_diameter;
      sb[0].par    <= '0;
      sb[0].up     <= '0;
      sb[0].az     <= '0;
      p0_dec       <= declination;
      div[0].rem   <= '0;
      div[0].den   <= den_in;
      div[0].num   <= (MOON_K << 16) + DIV_STEPS'(den_in >> 1);
    end
  end

  logic signed [VEC_W-1:0] mb_up;
  vec_t v1 [0:CORDIC_STEPS];
  vec_t v2 [0:CORDIC_STEPS];

  for (genvar k = 1; k <= LAST; k++) begin : g_line
    sb_t sb_next;
    always_comb begin
      sb_next = sb[k-1];
      if (k == P_UP)  sb_next.up  = mb_up;
      if (k == P_PAR) sb_next.par = div[DIV_STEPS].num;
      if (k == P_AZ)  sb_next.az  = to32(v1[CORDIC_STEPS].z[ANGLE_BITS-1:0]);
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (adv) vld[k] <= vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) sb[k] <= sb_next;
    end
  end

  // ---------------- parallax divider chain ----------------
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    eqhrs_div_cell u_div (
      .clk (clk),
      .en  (adv),
      .d   (div[k]),
      .q   (div[k+1])
    );
  end

  // ---------------- rotation chains ----------------
  rot_t rl [0:CORDIC_STEPS];
  rot_t rd [0:CORDIC_STEPS];
  rot_t rh [0:CORDIC_STEPS];

  assign rl[0] = rot_init(site_latitude);
  assign rd[0] = rot_init(p0_dec);
  assign rh[0] = rot_init(sb[0].ha);

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    localparam logic signed [Z_W-1:0] STEP = atan_step(k);
    eqhrs_rot_cell u_lat (
      .clk (clk), .en (adv), .shift (SHIFT_W'(k)), .step (STEP),
      .d (rl[k]), .q (rl[k+1])
    );
    eqhrs_rot_cell u_dec (
      .clk (clk), .en (adv), .shift (SHIFT_W'(k)), .step (STEP),
      .d (rd[k]), .q (rd[k+1])
    );
    eqhrs_rot_cell u_ha (
      .clk (clk), .en (adv), .shift (SHIFT_W'(k)), .step (STEP),
      .d (rh[k]), .q (rh[k+1])
    );
  end

  // undo the half-turn fold
  logic signed [ROT_W-1:0] cl, sl, cd, sd, ch, sh;
  assign cl = rl[CORDIC_STEPS].neg ? -rl[CORDIC_STEPS].x : rl[CORDIC_STEPS].x;
  assign sl = rl[CORDIC_STEPS].neg ? -rl[CORDIC_STEPS].y : rl[CORDIC_STEPS].y;
  assign cd = rd[CORDIC_STEPS].neg ? -rd[CORDIC_STEPS].x : rd[CORDIC_STEPS].x;
  assign sd = rd[CORDIC_STEPS].neg ? -rd[CORDIC_STEPS].y : rd[CORDIC_STEPS].y;
  assign ch = rh[CORDIC_STEPS].neg ? -rh[CORDIC_STEPS].x : rh[CORDIC_STEPS].x;
  assign sh = rh[CORDIC_STEPS].neg ? -rh[CORDIC_STEPS].y : rh[CORDIC_STEPS].y;

  // ---------------- product stages ----------------
  logic signed [ROT_W-1:0] ma_sc, ma_west, ma_sdcl, ma_sdsl, ma_sl, ma_cl;
  logic signed [VEC_W-1:0] mb_south, mb_west;

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_sc   <= vmul(ch, cd);
      ma_west <= vmul(sh, cd);
      ma_sdcl <= vmul(sd, cl);
      ma_sdsl <= vmul(sd, sl);
      ma_sl   <= sl;
      ma_cl   <= cl;
    end
  end

  // south = S sin(lat) - sin(dec) cos(lat); up = S cos(lat) + sin(dec) sin(lat)
  always_ff @(posedge clk) begin
    if (adv) begin
      mb_south <= VEC_W'(vmul(ma_sc, ma_sl)) - VEC_W'(ma_sdcl);
      mb_up    <= VEC_W'(vmul(ma_sc, ma_cl)) + VEC_W'(ma_sdsl);
      mb_west  <= VEC_W'(ma_west);
    end
  end

  // ---------------- azimuth vectoring chain ----------------
  assign v1[0] = vec_init(mb_south, mb_west);

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec1
    localparam logic signed [Z_W-1:0] STEP = atan_step(k);
    eqhrs_vec_cell u_vec (
      .clk (clk), .en (adv), .shift (SHIFT_W'(k)), .step (STEP),
      .d (v1[k]), .q (v1[k+1])
    );
  end

  // horizontal magnitude: remove the CORDIC gain
  logic signed [VEC_W-1:0]       mag_x;
  logic signed [VEC_W-1:0]       mag_y;
  logic signed [VEC_W+ROT_W-1:0] mag_p;

  assign mag_p = v1[CORDIC_STEPS].x * KINV;

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_x <= VEC_W'(mag_p >>> FRAC);
      mag_y <= sb[P_AZ-1].up;
    end
  end

  // ---------------- altitude vectoring chain ----------------
  assign v2[0] = vec_init(mag_x, mag_y);

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec2
    localparam logic signed [Z_W-1:0] STEP = atan_step(k);
    eqhrs_vec_cell u_vec (
      .clk (clk), .en (adv), .shift (SHIFT_W'(k)), .step (STEP),
      .d (v2[k]), .q (v2[k+1])
    );
  end

  // ---------------- rise/set classification ----------------
  logic signed [31:0]     last_alt [0:OBJECT_COUNT-1];
  logic [31:0]            alt32;
  logic signed [TH_W-1:0] alt_w;
  logic signed [TH_W-1:0] last_w;
  logic signed [TH_W-1:0] set_alt;
  logic signed [TH_W-1:0] up_alt;
  logic [31:0]            off;
  logic [2:0]             status;
  logic                   has_slot;
  sb_t                    fin;

  assign fin      = sb[LAST];
  assign alt32    = to32(v2[CORDIC_STEPS].z[ANGLE_BITS-1:0]);
  assign has_slot = (fin.idx < OBJECT_COUNT);

  always_comb begin
    alt_w  = TH_W'($signed(alt32));
    last_w = has_slot ? TH_W'(last_alt[fin.idx[OBJ_IW-1:0]]) : TH_W'(DOWN_ALT);
    set_alt = REFRACT_ALT;
    up_alt  = '0;
    // disc widens the band; lunar parallax lifts it, falling with distance
    if (fin.idx == OBJ_SUN) begin
      set_alt = REFRACT_ALT - TH_W'(fin.sun_d >> 1);
      up_alt  = set_alt + TH_W'(fin.sun_d);
    end else if (fin.idx == OBJ_MOON) begin
      set_alt = REFRACT_ALT + TH_W'(fin.par) - TH_W'(fin.moon_d >> 1);
      up_alt  = set_alt + TH_W'(fin.moon_d);
    end
    off = (fin.ha <= 32'h8000_0000) ? fin.ha : (32'd0 - fin.ha);
    if (alt_w > set_alt && alt_w < up_alt) begin
      status = (alt_w > last_w) ? ST_RISING : ST_SETTING;
    end else if (alt_w > up_alt) begin
      status = (off < HALF_DEGREE) ? ST_TRANSIT : ST_UP;
    end else begin
      status = ST_SET;
    end
  end

  // previous altitude per object, read and updated at the last stage only
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < OBJECT_COUNT; n++) last_alt[n] <= DOWN_ALT;
    end else if (adv && vld[LAST] && !fin.hide && has_slot) begin
      last_alt[fin.idx[OBJ_IW-1:0]] <= $signed(alt32);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[LAST];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.hide) begin
        hour_angle        <= '0;
        altitude          <= '0;
        azimuth           <= '0;
        visibility_status <= ST_SET;
        hidden            <= 1'b1;
      end else begin
        hour_angle        <= fin.ha;
        altitude          <= $signed(alt32);
        azimuth           <= $signed(fin.az);
        visibility_status <= status;
        hidden            <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
